// ===== rtl/ceq_pkg.sv =====
// ============================================================================
// ceq_pkg
// shared types and constants for the coalescing event queue
// ============================================================================
`default_nettype none
package ceq_pkg;
    localparam int SLOT_COUNT = 16;
    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int FILL_W = $clog2(SLOT_COUNT + 1);
    localparam logic [31:0] REPORT_INTERVAL = 32'd64;

    localparam logic [3:0] KIND_WAKE = 4'd0;
    localparam logic [3:0] KIND_CHARGE = 4'd3;
    localparam logic [3:0] KIND_REMINDER = 4'd7;
    localparam logic [3:0] KIND_STATE = 4'd8;
    localparam logic [3:0] KIND_MAX = 4'd10;

    localparam logic [1:0] ST_QUEUED = 2'd0;
    localparam logic [1:0] ST_COALESCED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_POP = 1'b1;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] count;
        logic        flag;
        logic [31:0] value;
        logic [6:0]  payload;
    } entry_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic   shift_en;   // cells at or above remove index take neighbor
        logic   [IDX_W-1:0] remove_idx;
        logic   write_en;   // write new entry at write index
        logic   [IDX_W-1:0] write_idx;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    function automatic logic kind_important(input logic [3:0] k);
        return (k == KIND_WAKE) || (k == KIND_REMINDER) || (k == KIND_STATE);
    endfunction

    function automatic logic kind_coalescible(input logic [3:0] k);
        return (k == KIND_WAKE) || ((k >= KIND_CHARGE) && (k <= KIND_STATE));
    endfunction
endpackage
`default_nettype wire

// ===== rtl/ceq_cell.sv =====
// ============================================================================
// ceq_cell
// one queue slot: holds an entry, takes its upper neighbor on a shift
// ============================================================================
`default_nettype none
module ceq_cell
    import ceq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic [IDX_W-1:0] my_idx,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     upper,
    input  wire entry_t     new_entry,
    output entry_t          entry
);
    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_en && (my_idx >= ctrl.remove_idx))
        begin
            entry_next = upper;
        end
        if (ctrl.write_en && (my_idx == ctrl.write_idx))
        begin
            entry_next = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
endmodule
`default_nettype wire

// ===== rtl/coalescing_event_queue_unit.sv =====
// ============================================================================
// coalescing_event_queue_unit
// bounded event queue with coalescing, eviction and pressure reporting
// ============================================================================
// the item is decided in the cycle after its input transfer (S_EXEC), and the result
// register is loaded at the end of that cycle, which raises m_tvalid (S_OUT)
// items do not overlap: transfer, then decide/shift of the cell chain, then result;
// a waiting result holds s_tready low until it transfers
// reset: control state, fill count and pressure counters clear asynchronously;
// slot contents are not cleared, slots at or above the fill count are never read
`default_nettype none
module coalescing_event_queue_unit
    import ceq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd, event_kind, well_formed, event_count, event_flag, event_value,
    // event_state, event_priority (bits 0..77, zero to 79)
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // submit_status, pop_valid, out_kind, out_count, out_flag, out_value,
    // out_state, out_priority, fill level, pressure_report (bits 0..84, zero to 87)
    output logic [87:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    // configuration register
    logic [3:0] idle_code_reg;
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {28'd0, idle_code_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_code_reg <= 4'd0;
        end
        else if (psel && penable && pwrite && (paddr == 2'd0))
        begin
            idle_code_reg <= pwdata[3:0];
        end
    end

    state_t state_reg, state_next;
    logic [79:0] in_reg;
    logic [87:0] out_reg, out_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0] rej_reg, rej_next, evi_reg, evi_next, last_reg, last_next;
    logic warn_reg, warn_next, rep_reg, rep_next;

    entry_t     cells [SLOT_COUNT];
    entry_t     uppers [SLOT_COUNT];
    entry_t     new_entry;
    cell_ctrl_t ctrl;

    // ------------------------------------------------------------------ chain
    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++)
        begin : g_cell
            if (g == SLOT_COUNT - 1)
            begin : g_top
                assign uppers[g] = cells[g];
            end
            else
            begin : g_mid
                assign uppers[g] = cells[g+1];
            end
            ceq_cell u_cell (
                .clk       (clk),
                .my_idx    (IDX_W'(g)),
                .ctrl      (ctrl),
                .upper     (uppers[g]),
                .new_entry (new_entry),
                .entry     (cells[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------ input decode
    logic        i_cmd, i_wf, i_flag;
    logic [3:0]  i_kind;
    logic [31:0] i_count, i_value;
    logic [6:0]  i_payload;
    assign i_cmd     = in_reg[0];
    assign i_kind    = in_reg[4:1];
    assign i_wf      = in_reg[5];
    assign i_count   = in_reg[37:6];
    assign i_flag    = in_reg[38];
    assign i_value   = in_reg[70:39];
    assign i_payload = in_reg[77:71];

    // per-slot match vectors, each slot compared in parallel
    logic [SLOT_COUNT-1:0] valid_v, same_v, unimp_v, state_v;
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            valid_v[i] = (FILL_W'(i) < fill_reg);
            same_v[i]  = valid_v[i] && (cells[i].kind == i_kind);
            unimp_v[i] = valid_v[i] && !kind_important(cells[i].kind);
            state_v[i] = valid_v[i] && (cells[i].kind == KIND_STATE);
        end
    end

    // first-set finders over the slots
    logic             same_hit, unimp_hit, state_hit;
    logic [IDX_W-1:0] same_idx, unimp_idx, state_idx;
    always_comb
    begin
        same_hit = 1'b0; unimp_hit = 1'b0; state_hit = 1'b0;
        same_idx = '0; unimp_idx = '0; state_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (same_v[i])
            begin
                same_hit = 1'b1; same_idx = IDX_W'(i);
            end
            if (unimp_v[i])
            begin
                unimp_hit = 1'b1; unimp_idx = IDX_W'(i);
            end
            if (state_v[i])
            begin
                state_hit = 1'b1; state_idx = IDX_W'(i);
            end
        end
    end

    // ---------------------------------------------------------- decide step
    logic [IDX_W-1:0] last_idx;
    logic [32:0] sat_sum;
    logic [31:0] n_count, press;
    logic        n_flag, full;
    assign last_idx = IDX_W'(fill_reg - FILL_W'(1));
    assign full = (fill_reg >= FILL_W'(SLOT_COUNT));

    // merge target: a state change only merges with the newest entry
    logic             co_hit;
    logic [IDX_W-1:0] co_idx;
    always_comb
    begin
        if (i_kind == KIND_STATE)
        begin
            co_hit = (fill_reg != '0) && (cells[last_idx].kind == KIND_STATE);
            co_idx = last_idx;
        end
        else
        begin
            co_hit = same_hit;
            co_idx = same_idx;
        end
    end

    always_comb
    begin
        ctrl = '0;
        fill_next = fill_reg;
        rej_next = rej_reg;
        evi_next = evi_reg;
        last_next = last_reg;
        warn_next = warn_reg;
        rep_next = rep_reg;
        out_next = '0;
        press = '0;
        n_count = (i_count == 32'd0) ? 32'd1 : i_count;
        n_flag = (i_kind == KIND_STATE) ? (i_value != {28'd0, idle_code_reg}) : i_flag;
        sat_sum = 33'd0;
        new_entry = '0;
        if (state_reg == S_EXEC)
        begin
            if (i_cmd == CMD_POP)
            begin
                if (fill_reg == '0)
                begin
                    if (warn_reg)
                    begin
                        warn_next = 1'b0;
                        rep_next = 1'b1;
                        last_next = rej_reg + evi_reg;
                        out_next[84] = 1'b1;
                    end
                end
                else
                begin
                    out_next[2]     = 1'b1;
                    out_next[6:3]   = cells[0].kind;
                    out_next[38:7]  = cells[0].count;
                    out_next[39]    = cells[0].flag;
                    out_next[71:40] = cells[0].value;
                    out_next[78:72] = cells[0].payload;
                    ctrl.shift_en = 1'b1;
                    ctrl.remove_idx = '0;
                    fill_next = fill_reg - FILL_W'(1);
                end
            end
            else if (!i_wf || (i_kind > KIND_MAX))
            begin
                rej_next = rej_reg + 32'd1;
                out_next[1:0] = ST_REJECTED;
            end
            else if (kind_coalescible(i_kind) && co_hit)
            begin
                if (i_kind == KIND_STATE)
                begin
                    n_flag = n_flag | cells[co_idx].flag;
                end
                else if (kind_important(i_kind))
                begin
                    sat_sum = {1'b0, cells[co_idx].count} + {1'b0, n_count};
                    n_count = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
                end
                ctrl.shift_en = 1'b1;
                ctrl.remove_idx = co_idx;
                ctrl.write_en = 1'b1;
                ctrl.write_idx = last_idx;
                out_next[1:0] = ST_COALESCED;
            end
            else if (full)
            begin
                if (kind_important(i_kind) && unimp_hit)
                begin
                    evi_next = evi_reg + 32'd1;
                    ctrl.shift_en = 1'b1;
                    ctrl.remove_idx = unimp_idx;
                    ctrl.write_en = 1'b1;
                    ctrl.write_idx = last_idx;
                end
                else if ((i_kind == KIND_STATE) && state_hit)
                begin
                    evi_next = evi_reg + 32'd1;
                    n_flag = n_flag | cells[state_idx].flag;
                    ctrl.shift_en = 1'b1;
                    ctrl.remove_idx = state_idx;
                    ctrl.write_en = 1'b1;
                    ctrl.write_idx = last_idx;
                end
                else
                begin
                    rej_next = rej_reg + 32'd1;
                    out_next[1:0] = ST_REJECTED;
                end
                // pressure counted after this step's eviction or reject
                press = rej_next + evi_next - last_reg;
                if (!rep_reg || (press >= REPORT_INTERVAL))
                begin
                    warn_next = 1'b1;
                end
            end
            else
            begin
                ctrl.write_en = 1'b1;
                ctrl.write_idx = IDX_W'(fill_reg);
                fill_next = fill_reg + FILL_W'(1);
            end
            new_entry.kind = i_kind;
            new_entry.count = n_count;
            new_entry.flag = n_flag;
            new_entry.value = i_value;
            new_entry.payload = i_payload;
            out_next[83:79] = 5'(fill_next);
        end
    end

    // ------------------------------------------------------------ sequencer
    logic s_fire, m_fire;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_fire) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (m_fire) state_next = s_fire ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // output register releases its slot when taken, accepting the next item then
    always_comb
    begin
        case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_OUT:   s_tready = m_tready;
            default: s_tready = 1'b0;
        endcase
        m_tvalid = (state_reg == S_OUT);
    end
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            rej_reg   <= '0;
            evi_reg   <= '0;
            last_reg  <= '0;
            warn_reg  <= 1'b0;
            rep_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rej_reg   <= rej_next;
            evi_reg   <= evi_next;
            last_reg  <= last_next;
            warn_reg  <= warn_next;
            rep_reg   <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_reg <= s_tdata;
        end
        if (state_reg == S_EXEC)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(SLOT_COUNT)) else $error("fill over depth");
    a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_OUT) else $error("exec not one cycle");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_EXEC |=> $stable(fill_reg)) else $error("fill moved idle");
`endif
endmodule
`default_nettype wire

// ===== tb/ceq_checker.sv =====
// ============================================================================
// ceq_checker
// watches the event and result streams, predicts each result, compares fields
// ============================================================================
`default_nettype none
module ceq_checker
    import ceq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [87:0] m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               pending,
    output int               failures
);
    timeunit 1ns;
    timeprecision 1ps;

    entry_t      slots[$];
    logic [87:0] due_results[$];
    logic [31:0] reject_cnt;
    logic [31:0] evict_cnt;
    logic [31:0] last_pressure;
    logic        warn_flag;
    logic        reported;
    logic [3:0]  idle_code;

    function automatic logic urgent(input logic [3:0] k);
        return (k == KIND_WAKE) || (k == KIND_REMINDER) || (k == KIND_STATE);
    endfunction

    function automatic logic mergeable(input logic [3:0] k);
        return (k == KIND_WAKE) || ((k >= KIND_CHARGE) && (k <= KIND_STATE));
    endfunction

    function automatic logic [1:0] queue_event(input logic [79:0] d);
        logic [3:0]  k;
        logic [31:0] c;
        logic        f;
        logic [31:0] v;
        logic [6:0]  p;
        int          victim;
        entry_t      e;
        k = d[4:1];
        c = d[37:6];
        f = d[38];
        v = d[70:39];
        p = {d[77:75], d[74:71]};
        if (!d[5] || k > KIND_MAX)
        begin
            reject_cnt++;
            return ST_REJECTED;
        end
        if (c == 32'd0) c = 32'd1;
        if (k == KIND_STATE) f = (v != {28'd0, idle_code});
        if (mergeable(k))
        begin
            for (int i = 0; i < slots.size(); i++)
            begin
                if (slots[i].kind != k) continue;
                if (k == KIND_STATE && i + 1 != slots.size()) continue;
                if (k == KIND_STATE) f |= slots[i].flag;
                else if (urgent(k))
                    c = (c > 32'hFFFF_FFFF - slots[i].count) ? 32'hFFFF_FFFF
                                                              : slots[i].count + c;
                slots.delete(i);
                e = '{kind: k, count: c, flag: f, value: v, payload: p};
                slots.push_back(e);
                return ST_COALESCED;
            end
        end
        if (slots.size() >= SLOT_COUNT)
        begin
            victim = -1;
            if (urgent(k))
            begin
                foreach (slots[i])
                    if (victim < 0 && !urgent(slots[i].kind)) victim = i;
                if (victim < 0 && k == KIND_STATE)
                    foreach (slots[i])
                        if (victim < 0 && slots[i].kind == KIND_STATE)
                        begin
                            victim = i;
                            f |= slots[i].flag;
                        end
            end
            if (victim >= 0)
            begin
                slots.delete(victim);
                evict_cnt++;
            end
            else
                reject_cnt++;
            if (!reported || (reject_cnt + evict_cnt - last_pressure) >= REPORT_INTERVAL)
                warn_flag = 1'b1;
            if (victim < 0) return ST_REJECTED;
        end
        e = '{kind: k, count: c, flag: f, value: v, payload: p};
        slots.push_back(e);
        return ST_QUEUED;
    endfunction

    // full result word for one accepted event transfer
    function automatic logic [87:0] next_result(input logic [79:0] d);
        logic [87:0] r;
        entry_t      h;
        r = '0;
        if (d[0] == CMD_SUBMIT)
            r[1:0] = queue_event(d);
        else if (slots.size() == 0)
        begin
            if (warn_flag)
            begin
                warn_flag = 1'b0;
                reported = 1'b1;
                last_pressure = reject_cnt + evict_cnt;
                r[84] = 1'b1;
            end
        end
        else
        begin
            h = slots.pop_front();
            r[2]     = 1'b1;
            r[6:3]   = h.kind;
            r[38:7]  = h.count;
            r[39]    = h.flag;
            r[71:40] = h.value;
            r[75:72] = h.payload[3:0];
            r[78:76] = h.payload[6:4];
        end
        r[83:79] = 5'(slots.size());
        return r;
    endfunction

    assign pending = due_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [87:0] want;
        if (!rst_n)
        begin
            slots.delete();
            due_results.delete();
            reject_cnt = '0;
            evict_cnt = '0;
            last_pressure = '0;
            warn_flag = 1'b0;
            reported = 1'b0;
            idle_code = '0;
            failures = 0;
        end
        else
        begin
            // register write from the config port
            if (psel && penable && pwrite && pready && paddr == 2'd0)
                idle_code = pwdata[3:0];
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result transfer %h", m_tdata);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want !== m_tdata)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"mismatch st %0d/%0d pv %0d/%0d kind %0d/%0d ",
                                      "cnt %h/%h flag %0d/%0d val %h/%h sta %0d/%0d ",
                                      "pri %0d/%0d depth %0d/%0d pres %0d/%0d"},
                                     want[1:0], m_tdata[1:0], want[2], m_tdata[2],
                                     want[6:3], m_tdata[6:3], want[38:7], m_tdata[38:7],
                                     want[39], m_tdata[39], want[71:40], m_tdata[71:40],
                                     want[75:72], m_tdata[75:72], want[78:76],
                                     m_tdata[78:76], want[83:79], m_tdata[83:79],
                                     want[84], m_tdata[84]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(next_result(s_tdata));
        end
    end
endmodule
`default_nettype wire

// ===== tb/coalescing_event_queue_unit_test.sv =====
// ============================================================================
// coalescing_event_queue_unit_test
// random and directed event traffic with configurable idle code and flow stalls
// ============================================================================
`default_nettype none
module coalescing_event_queue_unit_test;
    import ceq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          pending;
    int          failures;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    coalescing_event_queue_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ceq_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .pending(pending), .failures(failures)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // generous watchdog
    initial
    begin
        #20ms;
        $display("FAIL coalescing_event_queue_unit");
        $finish;
    end

    function automatic logic [79:0] pack_event(input logic cmd, input logic [3:0] kind,
                                               input logic wf, input logic [31:0] cnt,
                                               input logic flg, input logic [31:0] val,
                                               input logic [3:0] st, input logic [2:0] pri);
        return {2'b00, pri, st, val, flg, cnt, wf, kind, cmd};
    endfunction

    // one event transfer, with an optional gap before it
    task automatic push_event(input logic [79:0] d);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_idle_code(input logic [3:0] code);
        drain_results();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {28'd0, code};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_count();
        case ($urandom_range(4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            2: return $urandom_range(1, 5);
            default: return $urandom;
        endcase
    endfunction

    // random submit; non-mergeable kinds 1, 2, 9 and 10 take four of ten draws so the queue fills
    function automatic logic [79:0] random_submit();
        logic [3:0] k;
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: k = 4'd1 + 4'($urandom_range(1)) * 4'd8 + 4'($urandom_range(1));
            4: k = KIND_WAKE;
            5: k = KIND_REMINDER;
            6: k = KIND_STATE;
            7: k = 4'($urandom_range(3, 6));
            8: k = 4'($urandom_range(11, 15));
            default: k = 4'($urandom_range(10));
        endcase
        v = ($urandom_range(1)) ? 32'($urandom_range(15)) : $urandom;
        return pack_event(CMD_SUBMIT, k, $urandom_range(15) != 0, pick_count(),
                          1'($urandom_range(1)), v, 4'($urandom_range(15)),
                          3'($urandom_range(7)));
    endfunction

    function automatic logic [79:0] random_pop();
        return pack_event(CMD_POP, 4'($urandom), 1'($urandom), $urandom, 1'($urandom),
                          $urandom, 4'($urandom), 3'($urandom));
    endfunction

    // fill bursts that can overflow the queue, then drains that can run past empty
    task automatic traffic_burst(output int n_sent);
        int n_fill;
        int n_drain;
        n_fill = $urandom_range(4, 24);
        n_drain = $urandom_range(4, 22);
        n_sent = n_fill + n_drain;
        repeat (n_fill)
            push_event(($urandom_range(9) == 0) ? random_pop() : random_submit());
        repeat (n_drain)
            push_event(($urandom_range(9) == 0) ? random_submit() : random_pop());
    endtask

    initial
    begin
        int sent;
        int n_burst;
        logic held;
        int idle_of[4] = '{0, 78, 0, 32};
        int stall_of[4] = '{0, 0, 78, 32};
        logic [3:0] code_of[4];
        code_of = '{4'd15, 4'd0, 4'd7, 4'($urandom_range(15))};
        held = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes, every kind, state change at idle
        push_event(pack_event(CMD_POP, 4'd0, 1'b0, 32'd0, 1'b0, 32'd0, 4'd0, 3'd0));
        push_event(pack_event(CMD_SUBMIT, KIND_WAKE, 1'b1, 32'd0, 1'b0, 32'd0, 4'd0, 3'd0));
        push_event(pack_event(CMD_SUBMIT, KIND_WAKE, 1'b1, 32'hFFFF_FFFF, 1'b1,
                              32'h7FFF_FFFF, 4'd15, 3'd7));
        push_event(pack_event(CMD_SUBMIT, KIND_STATE, 1'b1, 32'd3, 1'b1, 32'd0, 4'd1, 3'd1));
        push_event(pack_event(CMD_SUBMIT, KIND_STATE, 1'b1, 32'd3, 1'b0, 32'd5, 4'd2, 3'd2));
        push_event(pack_event(CMD_SUBMIT, 4'd11, 1'b1, 32'd1, 1'b0, 32'd0, 4'd0, 3'd0));
        push_event(pack_event(CMD_SUBMIT, 4'd2, 1'b0, 32'd1, 1'b0, 32'd0, 4'd0, 3'd0));
        for (int k = 1; k <= 10; k++)
            push_event(pack_event(CMD_SUBMIT, 4'(k), 1'b1, 32'(k), k[0],
                                  32'h8000_0000, 4'(k), 3'(k)));
        // overflow so rejects show up and the pressure warning is raised
        repeat (8)
            push_event(pack_event(CMD_SUBMIT, 4'd9, 1'b1, 32'd1, 1'b1, 32'd1, 4'd3, 3'd4));
        repeat (4)
            push_event(pack_event(CMD_POP, 4'd0, 1'b1, 32'd0, 1'b0, 32'd0, 4'd0, 3'd0));

        // random phases, idle code changed between them
        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_idle_code(code_of[ph]);
            send_idle_pct = idle_of[ph];
            recv_stall_pct = stall_of[ph];
            while (sent < (ph + 1) * 215)
            begin
                traffic_burst(n_burst);
                sent += n_burst;
                // hold the sender once until the block has caught up
                if (ph == 1 && !held)
                begin
                    drain_results();
                    held = 1'b1;
                end
            end
        end
        drain_results();
        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("PASS coalescing_event_queue_unit");
        else
            $display("FAIL coalescing_event_queue_unit");
        $finish;
    end
endmodule
`default_nettype wire
